FILE: design/hap_pkg.sv
// Shared constants, microcode program and coefficient function for the allpass Hilbert block.
`timescale 1ns / 1ps

package hap_pkg;

    localparam int NUM_SECTIONS = 12;
    localparam int CASCADE_LEN  = 6;
    localparam int SEC_W        = 4;
    localparam int STEP_W       = 4;
    localparam int UC_DEPTH     = 15;

    localparam longint unsigned PI_E9   = 64'd3141592654;
    localparam longint unsigned TEN_E13 = 64'd10000000000000;

    // Pole frequencies in units of 1e-4.
    localparam longint unsigned POLE_E4 [NUM_SECTIONS] = '{
        64'd3609, 64'd27412, 64'd111573, 64'd447581, 64'd1796242, 64'd7984578,
        64'd12524, 64'd55671, 64'd223423, 64'd896271, 64'd3647914, 64'd27701114
    };

    typedef logic [1:0] t_cond;
    localparam t_cond UC_NEXT    = 2'd0;
    localparam t_cond UC_WAIT_IN = 2'd1;
    localparam t_cond UC_EMIT    = 2'd2;

    typedef struct packed {
        logic              mul_en;
        logic              path;
        logic [SEC_W-1:0]  sec;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd14;

    // Real and imaginary sections alternate so that each multiply overlaps
    // the add of the section before it in the other cascade.
    localparam t_uword UCODE [UC_DEPTH] = '{
        '{1'b0, 1'b0, 4'd0,  UC_WAIT_IN, 4'd0},
        '{1'b1, 1'b0, 4'd0,  UC_NEXT,    4'd0},
        '{1'b1, 1'b1, 4'd6,  UC_NEXT,    4'd0},
        '{1'b1, 1'b0, 4'd1,  UC_NEXT,    4'd0},
        '{1'b1, 1'b1, 4'd7,  UC_NEXT,    4'd0},
        '{1'b1, 1'b0, 4'd2,  UC_NEXT,    4'd0},
        '{1'b1, 1'b1, 4'd8,  UC_NEXT,    4'd0},
        '{1'b1, 1'b0, 4'd3,  UC_NEXT,    4'd0},
        '{1'b1, 1'b1, 4'd9,  UC_NEXT,    4'd0},
        '{1'b1, 1'b0, 4'd4,  UC_NEXT,    4'd0},
        '{1'b1, 1'b1, 4'd10, UC_NEXT,    4'd0},
        '{1'b1, 1'b0, 4'd5,  UC_NEXT,    4'd0},
        '{1'b1, 1'b1, 4'd11, UC_NEXT,    4'd0},
        '{1'b0, 1'b0, 4'd0,  UC_NEXT,    4'd0},
        '{1'b0, 1'b0, 4'd0,  UC_EMIT,    4'd0}
    };

    // Bilinear allpass coefficient c = (a - s) / (a + s), rounded half up on the magnitude.
    function automatic longint hap_coef(input int idx, input longint unsigned rate,
                                        input int frac);
        longint unsigned s;
        longint unsigned a;
        longint unsigned d;
        longint unsigned r;
        longint unsigned q;
        longint unsigned mag;
        longint unsigned lim;
        logic            neg;
        s   = 64'd2 * rate * TEN_E13;
        a   = 64'd30 * POLE_E4[idx] * PI_E9;
        d   = a + s;
        neg = (a < s);
        r   = neg ? (s - a) : (a - s);
        q   = 64'd0;
        for (int k = 0; k <= frac; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        mag = (q + 64'd1) >> 1;
        lim = 64'd1 << frac;
        if (neg) begin
            if (mag > lim) begin
                mag = lim;
            end
            return -$signed(mag);
        end
        if (mag > lim - 64'd1) begin
            mag = lim - 64'd1;
        end
        return $signed(mag);
    endfunction

endpackage

FILE: design/hilbert_allpass_quadrature.sv
// Top level of the twelve-pole allpass-pair Hilbert transformer.
`timescale 1ns / 1ps

// The input channel takes one signed sample per transaction on i_valid and
// o_stall. The output channel delivers the real and imaginary samples of one
// result per transaction on o_valid and i_stall.
// A microcode program steps one shared multiplier through all twelve allpass
// sections, alternating the two cascades so that the multiply of one section
// overlaps the add and saturation of the section before it.
// A result reaches the output register after twelve multiply steps, one closing
// add step and one emit step. The block can accept the next sample in the cycle
// after it loads a result, so it takes no new sample while the program is still
// running through the steps of the last one.
// A finished result waits in the output register while the next sample is
// processed; if the receiver still stalls when the next result is ready, the
// program holds at its emit step and o_stall stays high.
// Reset clears all section memories, the step counter and the output valid.
module hilbert_allpass_quadrature
    import hap_pkg::*;
#(
    parameter int SAMPLE_RATE    = 44100,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_real_out,
    output logic signed [SAMPLE_BITS-1:0] o_imag_out
);

    localparam int SW   = SAMPLE_BITS;
    localparam int MW   = SAMPLE_BITS + 2;
    localparam int DW   = MW + 1;
    localparam int CW   = COEF_FRAC_BITS + 1;
    localparam int PW   = DW + CW;
    localparam int SUMW = MW + 3;

    localparam longint COEF_TAB [NUM_SECTIONS] = '{
        hap_coef(0, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(1, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(2, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(3, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(4, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(5, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(6, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(7, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(8, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(9, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(10, SAMPLE_RATE, COEF_FRAC_BITS),
        hap_coef(11, SAMPLE_RATE, COEF_FRAC_BITS)
    };

    logic [STEP_W-1:0]        r_step;
    logic [STEP_W-1:0]        n_step;
    logic signed [MW-1:0]     r_xr;
    logic signed [MW-1:0]     r_xi;
    logic signed [MW-1:0]     r_prev_in  [NUM_SECTIONS];
    logic signed [MW-1:0]     r_prev_out [NUM_SECTIONS];
    logic signed [PW-1:0]     r_prod;
    logic signed [MW-1:0]     r_a_x;
    logic [SEC_W-1:0]         r_a_sec;
    logic                     r_a_path;
    logic                     r_a_en;
    logic                     r_out_valid;
    logic signed [SW-1:0]     r_real;
    logic signed [SW-1:0]     r_imag;

    t_uword                   w_uw;
    logic                     w_accept;
    logic                     w_emit;
    logic signed [MW-1:0]     w_x;
    logic signed [MW-1:0]     w_in_ext;
    logic signed [DW-1:0]     w_diff;
    logic signed [CW-1:0]     w_coef;
    logic signed [PW-1:0]     w_rnd;
    logic signed [SUMW-1:0]   w_sum;
    logic signed [MW-1:0]     w_y;
    logic signed [SW-1:0]     w_real_sat;
    logic signed [SW-1:0]     w_imag_sat;

    assign w_uw     = UCODE[r_step];
    assign o_stall  = (r_step != STEP_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_emit   = (w_uw.cond == UC_EMIT) && !(r_out_valid && i_stall);

    always_comb begin
        n_step = r_step;
        unique case (w_uw.cond)
            UC_NEXT: begin
                n_step = r_step + 1'b1;
            end
            UC_WAIT_IN: begin
                if (i_valid) begin
                    n_step = r_step + 1'b1;
                end
            end
            UC_EMIT: begin
                if (w_emit) begin
                    n_step = w_uw.target;
                end
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    assign w_in_ext = {{2{i_sample_in[SW-1]}}, i_sample_in};
    assign w_x      = w_uw.path ? r_xi : r_xr;
    assign w_diff   = {w_x[MW-1], w_x} - {r_prev_out[w_uw.sec][MW-1], r_prev_out[w_uw.sec]};
    assign w_coef   = CW'(COEF_TAB[w_uw.sec]);

    assign w_rnd = r_prod + (PW'(1) << (COEF_FRAC_BITS - 1));
    assign w_sum = {w_rnd[PW-1], w_rnd[PW-1:COEF_FRAC_BITS]}
                 + {{3{r_prev_in[r_a_sec][MW-1]}}, r_prev_in[r_a_sec]};

    always_comb begin
        if ((&w_sum[SUMW-1:MW-1]) || !(|w_sum[SUMW-1:MW-1])) begin
            w_y = w_sum[MW-1:0];
        end else begin
            w_y = {w_sum[SUMW-1], {(MW-1){~w_sum[SUMW-1]}}};
        end
    end

    always_comb begin
        if ((&r_xr[MW-1:SW-1]) || !(|r_xr[MW-1:SW-1])) begin
            w_real_sat = r_xr[SW-1:0];
        end else begin
            w_real_sat = {r_xr[MW-1], {(SW-1){~r_xr[MW-1]}}};
        end
        if ((&r_xi[MW-1:SW-1]) || !(|r_xi[MW-1:SW-1])) begin
            w_imag_sat = r_xi[SW-1:0];
        end else begin
            w_imag_sat = {r_xi[MW-1], {(SW-1){~r_xi[MW-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_a_en      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SECTIONS; i++) begin
                r_prev_in[i]  <= '0;
                r_prev_out[i] <= '0;
            end
        end else begin
            r_step <= n_step;
            r_a_en <= w_uw.mul_en;
            if (r_a_en) begin
                r_prev_in[r_a_sec]  <= r_a_x;
                r_prev_out[r_a_sec] <= w_y;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xr <= w_in_ext;
            r_xi <= w_in_ext;
        end else if (r_a_en) begin
            if (r_a_path) begin
                r_xi <= w_y;
            end else begin
                r_xr <= w_y;
            end
        end
        r_prod   <= w_diff * w_coef;
        r_a_x    <= w_x;
        r_a_sec  <= w_uw.sec;
        r_a_path <= w_uw.path;
        if (w_emit) begin
            r_real <= w_real_sat;
            r_imag <= w_imag_sat;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_real_out = r_real;
    assign o_imag_out = r_imag;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_step == 4'd1))
        else $error("accepted transaction did not start the program");

    a_add_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_en |-> ($past(w_uw.mul_en) && (r_a_sec == $past(w_uw.sec))))
        else $error("add stage out of step with multiply stage");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_step) == STEP_EMIT))
        else $error("result loaded outside the emit step");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_en || (w_uw.mul_en)) |-> !w_accept)
        else $error("transaction accepted while sections are running");

endmodule

FILE: tb/hap_checker.sv
// Checker that predicts and compares the quadrature outputs of the allpass Hilbert block.
`timescale 1ns / 1ps

module hap_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [23:0] i_sample,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [23:0] i_real,
    input  logic signed [23:0] i_imag,
    output int                 o_mismatches,
    output int                 o_pending
);

    localparam int SAMPLE_W  = 24;
    localparam int MEM_W     = 26;
    localparam int FRAC      = 17;
    localparam int N_SEC     = 12;
    localparam int HALF_LEN  = 6;
    localparam int RATE      = 44100;
    localparam int MAX_SHOWN = 10;

    localparam longint unsigned PI_SCALED  = 64'd3141592654;
    localparam longint unsigned RATE_SCALE = 64'd10000000000000;

    // Pole frequencies in units of 1e-4, real cascade first.
    localparam longint unsigned POLES [N_SEC] = '{
        64'd3609, 64'd27412, 64'd111573, 64'd447581, 64'd1796242, 64'd7984578,
        64'd12524, 64'd55671, 64'd223423, 64'd896271, 64'd3647914, 64'd27701114
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_quad_pair;

    longint     coef_tbl [N_SEC];
    longint     sec_x_prev [N_SEC];
    longint     sec_y_prev [N_SEC];
    t_quad_pair quad_expected_q [$];
    int         result_index;

    function automatic longint bilinear_coef(input int idx);
        longint unsigned s;
        longint unsigned a;
        longint unsigned d;
        longint unsigned r;
        longint unsigned q;
        longint unsigned mag;
        longint unsigned lim;
        logic            neg;
        s   = 64'd2 * longint'(RATE) * RATE_SCALE;
        a   = 64'd30 * POLES[idx] * PI_SCALED;
        d   = a + s;
        neg = (a < s);
        r   = neg ? (s - a) : (a - s);
        q   = 64'd0;
        for (int k = 0; k <= FRAC; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        mag = (q + 64'd1) >> 1;
        lim = 64'd1 << FRAC;
        if (neg) begin
            if (mag > lim) begin
                mag = lim;
            end
            return -longint'(mag);
        end
        if (mag > lim - 64'd1) begin
            mag = lim - 64'd1;
        end
        return longint'(mag);
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // One first-order allpass section: y = c*(x - y_prev) + x_prev, rounded half up.
    function automatic longint allpass_section(input int idx, input longint x);
        longint diff;
        longint prod;
        longint y;
        diff = x - sec_y_prev[idx];
        prod = (coef_tbl[idx] * diff + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        y    = clamp_bits(prod + sec_x_prev[idx], MEM_W);
        sec_x_prev[idx] = x;
        sec_y_prev[idx] = y;
        return y;
    endfunction

    function automatic t_quad_pair hilbert_predict(input logic signed [SAMPLE_W-1:0] sample);
        longint     re;
        longint     im;
        t_quad_pair pair;
        re = longint'(sample);
        im = longint'(sample);
        for (int j = 0; j < HALF_LEN; j++) begin
            re = allpass_section(j, re);
        end
        for (int j = HALF_LEN; j < N_SEC; j++) begin
            im = allpass_section(j, im);
        end
        pair.re = SAMPLE_W'(clamp_bits(re, SAMPLE_W));
        pair.im = SAMPLE_W'(clamp_bits(im, SAMPLE_W));
        return pair;
    endfunction

    initial begin
        for (int i = 0; i < N_SEC; i++) begin
            coef_tbl[i] = bilinear_coef(i);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_quad_pair want;
        if (!i_rst_n) begin
            for (int i = 0; i < N_SEC; i++) begin
                sec_x_prev[i] = 0;
                sec_y_prev[i] = 0;
            end
            quad_expected_q.delete();
            o_mismatches = 0;
            result_index = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (quad_expected_q.size() == 0) begin
                    if (o_mismatches < MAX_SHOWN) begin
                        $display("Unexpected result transaction %0d: real %0d imag %0d",
                                 result_index, i_real, i_imag);
                    end
                    o_mismatches++;
                end else begin
                    want = quad_expected_q.pop_front();
                    if (i_real !== want.re || i_imag !== want.im) begin
                        if (o_mismatches < MAX_SHOWN) begin
                            $display("Mismatch at result %0d: real exp %0d got %0d, imag exp %0d got %0d",
                                     result_index, want.re, i_real, want.im, i_imag);
                        end
                        o_mismatches++;
                    end
                end
                result_index++;
            end
            if (i_in_valid && !i_in_stall) begin
                quad_expected_q.push_back(hilbert_predict(i_sample));
            end
        end
        o_pending = quad_expected_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the testbench: clock, reset, sample stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int TOTAL_ITEMS = 1450;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 40;

    localparam logic signed [23:0] MAX_SAMPLE = 24'sh7FFFFF;
    localparam logic signed [23:0] MIN_SAMPLE = 24'sh800000;

    localparam logic signed [23:0] EDGE_SAMPLES [22] = '{
        24'sd0, 24'sd1, -24'sd1, MAX_SAMPLE, MIN_SAMPLE, 24'sd0,
        MAX_SAMPLE, MIN_SAMPLE, MAX_SAMPLE, MIN_SAMPLE, MAX_SAMPLE, MIN_SAMPLE,
        MAX_SAMPLE, MIN_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE,
        MIN_SAMPLE, MIN_SAMPLE, MIN_SAMPLE, MIN_SAMPLE
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] sample;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] real_out;
    logic signed [23:0] imag_out;
    int                 mismatches;
    int                 pending;
    int                 sent_count;
    int                 idle_odds;
    logic               hold_done;

    hilbert_allpass_quadrature u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_sample_in (sample),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_real_out  (real_out),
        .o_imag_out  (imag_out)
    );

    hap_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample     (sample),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_real       (real_out),
        .i_imag       (imag_out),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // A transaction is offered at a falling edge and held until the block takes it.
    task automatic send_sample(input logic signed [23:0] value);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = value;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
    endtask

    initial begin : stimulus
        logic signed [23:0] value;
        int                 walk;
        int                 pick;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        sent_count = 0;
        idle_odds  = 0;
        walk       = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (EDGE_SAMPLES[i]) begin
            send_sample(EDGE_SAMPLES[i]);
        end

        while (sent_count < TOTAL_ITEMS) begin
            if (sent_count % 100 == 0) begin
                idle_odds = (sent_count >= TOTAL_ITEMS - QUIET_TAIL) ? 0 :
                            $urandom_range(0, 1) * $urandom_range(2, 5);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                value = 24'($urandom);
            end else if (pick < 65) begin
                value = $urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE;
            end else if (pick < 80) begin
                value = 24'(int'($urandom_range(0, 511)) - 256);
            end else begin
                walk = walk + int'($urandom_range(0, 262143)) - 131072;
                if (walk > 8388607) begin
                    walk = 8388607;
                end else if (walk < -8388608) begin
                    walk = -8388608;
                end
                value = 24'(walk);
            end
            send_sample(value);
        end
        in_valid = 1'b0;

        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS hilbert_allpass_quadrature");
        end else begin
            $display("FAIL hilbert_allpass_quadrature");
        end
        $finish;
    end

    // The receiver stalls in short bursts and once holds off long enough to back up the block.
    initial begin : receiver
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                hold_done = 1'b1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial begin : watchdog
        #1000000;
        $display("FAIL hilbert_allpass_quadrature");
        $finish;
    end

endmodule

FILE: sim.f
design/hap_pkg.sv
design/hilbert_allpass_quadrature.sv
tb/hap_checker.sv
tb/testbench.sv
